// ----- hw/rtl/tfwss_pkg.sv -----
// ----------------------------------------------------------------------------
// tfwss_pkg
// Types and constants for the tuner frequency word and spur shift block:
// the spur window table, the MHz divisor and the rounding limit.
// ----------------------------------------------------------------------------
`default_nettype none

package tfwss_pkg;

  localparam int unsigned SPUR_ENTRIES = 17;
  localparam int unsigned HZ_W         = 30;
  localparam int unsigned REM_W        = 20;
  localparam int unsigned FRAC_BITS    = 6;

  localparam logic [HZ_W-1:0]  HZ_PER_MHZ  = 30'd1000000;
  localparam logic [REM_W-1:0] FRAC_HALF   = 20'd500000;
  localparam logic [REM_W-1:0] ROUND_LIMIT = 20'd7812;
  localparam logic [7:0]       DIR_BASE    = 8'ha0;

  // One spur window, both ends already scaled to Hz and inclusive
  typedef struct packed {
    logic [HZ_W-1:0] lo_hz;
    logic [HZ_W-1:0] hi_hz;
    logic [7:0]      value;
    logic [7:0]      dir;
  } spur_entry_t;

  // Selected spur result
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] dir_byte;
    logic       hit;
  } spur_res_t;

  localparam spur_entry_t SPUR_TABLE [SPUR_ENTRIES] = '{
    '{30'd64000000,  30'd65000000,  8'h92, 8'h07},
    '{30'd191200000, 30'd191800000, 8'he2, 8'h07},
    '{30'd205000000, 30'd206000000, 8'h2c, 8'h04},
    '{30'd212000000, 30'd213000000, 8'h1e, 8'h04},
    '{30'd226000000, 30'd227000000, 8'hd4, 8'h07},
    '{30'd98643000,  30'd99643000,  8'h9c, 8'h07},
    '{30'd172643000, 30'd173643000, 8'hd4, 8'h07},
    '{30'd190843000, 30'd191443000, 8'hd4, 8'h07},
    '{30'd206643000, 30'd207643000, 8'hce, 8'h07},
    '{30'd224643000, 30'd225643000, 8'hce, 8'h07},
    '{30'd242643000, 30'd243643000, 8'hd4, 8'h07},
    '{30'd260643000, 30'd261643000, 8'hd4, 8'h07},
    '{30'd290643000, 30'd291643000, 8'hd4, 8'h07},
    '{30'd338643000, 30'd339643000, 8'h2c, 8'h04},
    '{30'd116643000, 30'd117643000, 8'h7a, 8'h07},
    '{30'd134843000, 30'd135443000, 8'h7a, 8'h07},
    '{30'd152643000, 30'd153643000, 8'h01, 8'h07}
  };

endpackage

`default_nettype wire

// ----- hw/rtl/tuner_frequency_word_and_spur_shift.sv -----
// ----------------------------------------------------------------------------
// tuner_frequency_word_and_spur_shift
// Throughput: one item per cycle while the output is not stalled; the
// four-stage restoring divide by 1e6 and fraction extraction run as a
// stage-per-slice pipeline.
// Reset clears the stage valid bits only; the payload registers are not reset.
// Maps a channel frequency in Hz to the spur shift bytes and a rounded
// 10.6 fixed-point MHz word.
// ----------------------------------------------------------------------------
`default_nettype none

module tuner_frequency_word_and_spur_shift (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [29:0] freq_hz,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       spur_value,
  output logic [7:0]       spur_dir_byte,
  output logic [15:0]      freq_word,
  output logic             spur_hit
);
  import tfwss_pkg::*;

  logic adv;

  logic v1, v2, v3, v4;

  logic [HZ_W-1:0]  rem1_next, rem1, rem2_next, rem2;
  logic [REM_W-1:0] rem3_next, rem3;
  logic [3:0]       q1_next, q1;
  logic [7:0]       q2_next, q2;
  logic [10:0]      w3_next, w3;
  logic [15:0]      word4_next;
  logic [HZ_W-1:0]  rem_c;
  logic [REM_W-1:0] rem_d;

  spur_res_t spur2;
  spur_res_t spur3;

  // Move every stage together unless the output holds a stalled result
  assign adv      = !(v4 && out_stall);
  assign in_stall = !adv;

  tfwss_spur_lookup u_spur (
    .clk     (clk),
    .adv     (adv),
    .freq_hz (freq_hz),
    .res     (spur2)
  );

  // Stage 1: quotient bits 10..7
  always_comb begin
    rem1_next = freq_hz;
    q1_next   = '0;
    for (int k = 0; k < 4; k++) begin
      if (rem1_next >= (HZ_PER_MHZ << (10 - k))) begin
        rem1_next      = rem1_next - (HZ_PER_MHZ << (10 - k));
        q1_next[3 - k] = 1'b1;
      end
    end
  end

  // Stage 2: quotient bits 6..3
  always_comb begin
    rem2_next = rem1;
    q2_next   = {q1, 4'b0000};
    for (int k = 0; k < 4; k++) begin
      if (rem2_next >= (HZ_PER_MHZ << (6 - k))) begin
        rem2_next      = rem2_next - (HZ_PER_MHZ << (6 - k));
        q2_next[3 - k] = 1'b1;
      end
    end
  end

  // Stage 3: quotient bits 2..0, then the first fraction bit
  always_comb begin
    rem_c   = rem2;
    w3_next = '0;
    for (int k = 0; k < 3; k++) begin
      if (rem_c >= (HZ_PER_MHZ << (2 - k))) begin
        rem_c          = rem_c - (HZ_PER_MHZ << (2 - k));
        w3_next[3 - k] = 1'b1;
      end
    end
    w3_next[10:4] = q2[6:0];
    rem3_next     = rem_c[REM_W-1:0];
    if (rem3_next > FRAC_HALF) begin
      rem3_next  = rem3_next - FRAC_HALF;
      w3_next[0] = 1'b1;
    end
  end

  // Stage 4: remaining fraction bits and round-up, wrapping at 16 bits
  always_comb begin
    rem_d      = rem3;
    word4_next = {w3, 5'b00000};
    for (int k = 1; k < FRAC_BITS; k++) begin
      if (rem_d > (FRAC_HALF >> k)) begin
        rem_d                  = rem_d - (FRAC_HALF >> k);
        word4_next[5 - k]      = 1'b1;
      end
    end
    if (rem_d > ROUND_LIMIT) begin
      word4_next = word4_next + 16'd1;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Advance the payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      rem1          <= rem1_next;
      q1            <= q1_next;
      rem2          <= rem2_next;
      q2            <= q2_next;
      rem3          <= rem3_next;
      w3            <= w3_next;
      spur3         <= spur2;
      freq_word     <= word4_next;
      spur_value    <= spur3.value;
      spur_dir_byte <= spur3.dir_byte;
      spur_hit      <= spur3.hit;
    end
  end

  assign out_valid = v4;

endmodule

`default_nettype wire

// ----- hw/rtl/tfwss_spur_lookup.sv -----
// ----------------------------------------------------------------------------
// tfwss_spur_lookup
// Two-stage spur window lookup: all windows are compared in the first
// stage, the first matching entry in table order is selected in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module tfwss_spur_lookup (
  input  wire logic                        clk,
  input  wire logic                        adv,
  input  wire logic [tfwss_pkg::HZ_W-1:0]  freq_hz,
  output tfwss_pkg::spur_res_t             res
);
  import tfwss_pkg::*;

  logic [SPUR_ENTRIES-1:0] hits_next;
  logic [SPUR_ENTRIES-1:0] hits;
  spur_res_t               res_next;

  // Compare the frequency against every window in parallel
  always_comb begin
    for (int i = 0; i < SPUR_ENTRIES; i++) begin
      hits_next[i] = (freq_hz >= SPUR_TABLE[i].lo_hz) && (freq_hz <= SPUR_TABLE[i].hi_hz);
    end
  end

  // Pick the lowest matching index; walk down so the earliest entry wins
  always_comb begin
    res_next.value    = 8'h00;
    res_next.dir_byte = DIR_BASE;
    res_next.hit      = 1'b0;
    for (int i = SPUR_ENTRIES - 1; i >= 0; i--) begin
      if (hits[i]) begin
        res_next.value    = SPUR_TABLE[i].value;
        res_next.dir_byte = DIR_BASE | SPUR_TABLE[i].dir;
        res_next.hit      = 1'b1;
      end
    end
  end

  // Advance both stages with the pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      hits <= hits_next;
      res  <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_tuner_frequency_word_and_spur_shift.sv -----
// ----------------------------------------------------------------------------
// tb_tuner_frequency_word_and_spur_shift
// Drives channel frequencies into the tuner word and spur shift block and
// checks every result against a predictor that scans its own copy of the
// spur windows and builds the rounded 10.6 MHz word by successive halving.
// Runs a directed set of edge cases, then random frequencies, many aimed at the
// window edges and fraction boundaries under several idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tuner_frequency_word_and_spur_shift;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SPUR_COUNT   = 17;
  localparam int unsigned MHZ_HZ       = 1000000;
  localparam int unsigned KHZ_HZ       = 1000;
  localparam int unsigned ROUND_THRESH = 7812;
  localparam logic [7:0]  DIR_OR_BITS  = 8'ha0;
  localparam int unsigned FRAC_STEPS   = 6;
  localparam int unsigned FRAC_LSB_HZ  = 15625;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 10;

  // Spur windows in table order: centre and half width in kHz
  localparam int unsigned WIN_CENTRE_KHZ [SPUR_COUNT] = '{
    64500, 191500, 205500, 212500, 226500, 99143, 173143, 191143, 207143,
    225143, 243143, 261143, 291143, 339143, 117143, 135143, 153143
  };
  localparam int unsigned WIN_HALF_KHZ [SPUR_COUNT] = '{
    500, 300, 500, 500, 500, 500, 500, 300, 500,
    500, 500, 500, 500, 500, 500, 300, 500
  };
  localparam logic [7:0] WIN_SHIFT [SPUR_COUNT] = '{
    8'h92, 8'he2, 8'h2c, 8'h1e, 8'hd4, 8'h9c, 8'hd4, 8'hd4, 8'hce,
    8'hce, 8'hd4, 8'hd4, 8'hd4, 8'h2c, 8'h7a, 8'h7a, 8'h01
  };
  localparam logic [7:0] WIN_DIR [SPUR_COUNT] = '{
    8'h07, 8'h07, 8'h04, 8'h04, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07,
    8'h07, 8'h07, 8'h07, 8'h07, 8'h04, 8'h07, 8'h07, 8'h07
  };

  typedef struct packed {
    logic [7:0]  shift;
    logic [7:0]  dir_byte;
    logic [15:0] word;
    logic        hit;
  } tuner_regs_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [29:0] freq_hz   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  spur_value;
  logic [7:0]  spur_dir_byte;
  logic [15:0] freq_word;
  logic        spur_hit;

  tuner_regs_t pending_regs [$];
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned freqs_sent  = 0;
  int unsigned regs_seen   = 0;
  int unsigned hits_seen   = 0;
  int unsigned mismatches  = 0;

  tuner_frequency_word_and_spur_shift u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .freq_hz       (freq_hz),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .spur_value    (spur_value),
    .spur_dir_byte (spur_dir_byte),
    .freq_word     (freq_word),
    .spur_hit      (spur_hit)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $display("timeout: %0d frequencies sent, %0d results seen", freqs_sent, regs_seen);
    $finish;
  end

  // Work out the register values for one channel frequency
  function automatic tuner_regs_t compute_tuner_regs(input logic [29:0] hz);
    tuner_regs_t r;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] rem;
    logic [31:0] div;
    logic [15:0] word;
    r.shift    = 8'h00;
    r.dir_byte = DIR_OR_BITS;
    r.hit      = 1'b0;
    // take the first window that covers the frequency
    for (int i = 0; i < SPUR_COUNT; i++) begin
      lo = (WIN_CENTRE_KHZ[i] - WIN_HALF_KHZ[i]) * KHZ_HZ;
      hi = (WIN_CENTRE_KHZ[i] + WIN_HALF_KHZ[i]) * KHZ_HZ;
      if (!r.hit && {2'b00, hz} >= lo && {2'b00, hz} <= hi) begin
        r.shift    = WIN_SHIFT[i];
        r.dir_byte = DIR_OR_BITS | WIN_DIR[i];
        r.hit      = 1'b1;
      end
    end
    // integer MHz, then six fraction bits by halving, then round up
    word = 16'({2'b00, hz} / MHZ_HZ);
    rem  = {2'b00, hz} % MHZ_HZ;
    div  = MHZ_HZ;
    for (int b = 0; b < FRAC_STEPS; b++) begin
      word = {word[14:0], 1'b0};
      div  = div >> 1;
      if (rem > div) begin
        rem     = rem - div;
        word[0] = 1'b1;
      end
    end
    if (rem > ROUND_THRESH) word = word + 16'd1;
    r.word = word;
    return r;
  endfunction

  // Random stall on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check each result transfer, then log each input transfer
  always @(posedge clk) begin
    tuner_regs_t exp_regs;
    if (!rst && out_valid && !out_stall) begin
      regs_seen++;
      if (spur_hit) hits_seen++;
      if (pending_regs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing pending: shift=%02h dir=%02h word=%04h hit=%0b",
                   $realtime, spur_value, spur_dir_byte, freq_word, spur_hit);
      end else begin
        exp_regs = pending_regs.pop_front();
        if (spur_value !== exp_regs.shift || spur_dir_byte !== exp_regs.dir_byte ||
            freq_word !== exp_regs.word || spur_hit !== exp_regs.hit) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: exp shift=%02h dir=%02h word=%04h hit=%0b, got shift=%02h dir=%02h word=%04h hit=%0b",
                     $realtime, exp_regs.shift, exp_regs.dir_byte, exp_regs.word,
                     exp_regs.hit, spur_value, spur_dir_byte, freq_word, spur_hit);
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      pending_regs.push_back(compute_tuner_regs(freq_hz));
      freqs_sent++;
    end
  end

  // Offer one frequency, with a random idle gap first, and hold it until taken
  task automatic send_freq(input logic [29:0] hz);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    freq_hz  <= hz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold off until every pending result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_regs.size() != 0) @(posedge clk);
  endtask

  // Pick a frequency near a window edge or a fraction boundary, or at random
  function automatic logic [29:0] pick_freq();
    int unsigned pick;
    int unsigned win;
    int signed   base;
    int signed   delta;
    int signed   deltas [6] = '{-1, 0, 1, 7812, 7813, 15624};
    pick = $urandom_range(99);
    if (pick < 30) begin
      win  = $urandom_range(SPUR_COUNT - 1);
      base = $urandom_range(1)
             ? int'((WIN_CENTRE_KHZ[win] - WIN_HALF_KHZ[win]) * KHZ_HZ)
             : int'((WIN_CENTRE_KHZ[win] + WIN_HALF_KHZ[win]) * KHZ_HZ);
      return 30'(base + int'($urandom_range(4)) - 2);
    end else if (pick < 50) begin
      base  = int'($urandom_range(1073)) * MHZ_HZ
              + int'($urandom_range(63)) * FRAC_LSB_HZ;
      delta = deltas[$urandom_range(5)];
      if (base + delta < 0) return '0;
      return 30'(base + delta);
    end else if (pick < 80) begin
      return 30'($urandom_range(999999999));
    end
    return 30'($urandom);
  endfunction

  // Edges of the field, window boundaries, overlap and fraction rounding
  task automatic test_directed();
    logic [29:0] edge_list [] = '{
      30'd0, 30'h3fffffff, 30'd999999999, 30'd1023999999, 30'd1024000000,
      30'd63999999, 30'd64000000, 30'd65000000, 30'd65000001,
      30'd191300000, 30'd190843000, 30'd191800000, 30'd191800001,
      30'd153643000, 30'd153643001, 30'd134843000, 30'd339643000,
      30'd500000, 30'd500001, 30'd7812, 30'd7813,
      30'd984375, 30'd999999, 30'd1000000, 30'd357913941
    };
    idle_pct  = 0;
    stall_pct = 0;
    foreach (edge_list[i]) send_freq(edge_list[i]);
    wait_drained();
  endtask

  // Random frequencies under one idle and stall mix
  task automatic test_random_mix(input int unsigned sender_idle,
                                 input int unsigned receiver_stall,
                                 input int unsigned count);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    repeat (count) send_freq(pick_freq());
  endtask

  // Send one at a time, letting the pipeline empty after each transfer
  task automatic test_drain_pause();
    idle_pct  = 0;
    stall_pct = 30;
    repeat (30) begin
      send_freq(pick_freq());
      wait_drained();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_mix(0, 0, 450);
    test_random_mix(62, 0, 450);
    test_random_mix(0, 62, 450);
    test_random_mix(9, 9, 450);
    test_drain_pause();

    // Let the tail drain, then look for stray results
    wait_drained();
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_regs.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", pending_regs.size());
    end

    $display("covered %0d frequencies, %0d results, %0d spur window hits",
             freqs_sent, regs_seen, hits_seen);
    $display("directed edges plus random mixes of idle and stall; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
